### design/tmps_pkg.sv
// Shared constants and types for the triangle maximum path sum block.
`timescale 1ns / 1ps

package tmps_pkg;

    // Deepest triangle supported, one chain cell per column.
    localparam int MAX_ROWS = 128;
    localparam int IDX_W    = $clog2(MAX_ROWS);

    // Fixed field widths.
    localparam int ENTRY_W  = 7;
    localparam int SUM_W    = 14;
    localparam int CFG_W    = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Width that holds both the row count register and MAX_ROWS itself.
    localparam int CNT_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Control broadcast from the update unit to every cell of the chain.
    typedef struct packed {
        logic             push;   // a new best sum enters the chain
        logic             pop;    // the head value was consumed, chain shifts
        logic [IDX_W-1:0] tail;   // cell that takes the new best sum
        logic [SUM_W-1:0] data;   // new best sum
    } cell_ctl_t;

endpackage

### design/triangle_max_path_sum.sv
// Top level of the triangle maximum path sum block.
`timescale 1ns / 1ps

// Entries of a number triangle arrive one per transfer, apex first and each
// row left to right; the block takes one entry every clock cycle. The best
// path sums of the previous row live in a chain of cells that acts as a
// queue: the head cell always holds the sum needed by the next entry, and each
// new sum is written into the tail. After the last entry of the last row (set
// by the row-count register, to be written through cfg_we/cfg_wdata only
// while the block is idle; the block does not enforce this) one transfer
// carries the largest path sum, and counting restarts for the next triangle.
// A finished result sits in an output register; input stalls only while that
// register is full and not being taken.
module triangle_max_path_sum
    import tmps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,     // num_rows
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,       // [6:0] entry_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata        // [13:0] max_sum
);

    logic                   accept;
    cell_ctl_t              ctl;
    logic                   res_valid;
    logic [SUM_W-1:0]       res_sum;
    logic [SUM_W-1:0]       chain [MAX_ROWS];
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SUM_W-1:0]       m_sum_reg, m_sum_next;

    // Take an entry unless a result waits and is not being taken.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tmps_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .entry_value (s_tdata[ENTRY_W-1:0]),
        .head_best   (chain[0]),
        .ctl         (ctl),
        .res_valid   (res_valid),
        .res_sum     (res_sum)
    );

    // Chain of column cells; on a pop, each cell below the tail shifts toward the head.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ROWS; gi++)
        begin : g_cell
            logic [SUM_W-1:0] upper;
            if (gi == MAX_ROWS - 1)
            begin : g_end
                assign upper = '0;
            end
            else
            begin : g_mid
                assign upper = chain[gi+1];
            end
            tmps_cell u_cell (
                .clk       (clk),
                .cell_idx  (IDX_W'(gi)),
                .ctl       (ctl),
                .next_best (upper),
                .best      (chain[gi])
            );
        end
    endgenerate

    // Output register.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_sum_next    = m_sum_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
            m_sum_next    = res_sum;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_sum_reg <= m_sum_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_sum_reg);

endmodule

### design/tmps_cell.sv
// One cell of the column-best chain: holds one best path sum.
`timescale 1ns / 1ps

module tmps_cell
    import tmps_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] cell_idx,   // position of this cell in the chain
    input  cell_ctl_t        ctl,
    input  logic [SUM_W-1:0] next_best,  // value held by the neighbor above
    output logic [SUM_W-1:0] best
);

    logic [SUM_W-1:0] best_reg;
    logic [SUM_W-1:0] best_next;

    // The tail cell takes the new sum; on a pop, cells ahead of it shift toward the head.
    always_comb
    begin
        best_next = best_reg;
        if (ctl.push)
        begin
            if (cell_idx == ctl.tail)
            begin
                best_next = ctl.data;
            end
            else if (ctl.pop && (cell_idx < ctl.tail))
            begin
                best_next = next_best;
            end
        end
    end

    // Payload storage, no reset needed.
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

### design/tmps_ctrl.sv
// Row and column counters, best-sum update and running bottom-row maximum.
`timescale 1ns / 1ps

module tmps_ctrl
    import tmps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               accept,
    input  logic [ENTRY_W-1:0] entry_value,
    input  logic [SUM_W-1:0]   head_best,   // previous row's best at this column
    output cell_ctl_t          ctl,
    output logic               res_valid,
    output logic [SUM_W-1:0]   res_sum
);

    logic [CFG_W-1:0] num_rows_reg, num_rows_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [SUM_W-1:0] left_reg, left_next;
    logic [SUM_W-1:0] bmax_reg, bmax_next;

    logic [CNT_W-1:0] rows_eff;
    logic             last_col;
    logic             last_row;
    logic [SUM_W-1:0] old_here;
    logic [SUM_W-1:0] left_cand;
    logic [SUM_W-1:0] pick;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] best;
    logic [SUM_W-1:0] bmax_upd;

    // Row count with zero taken as one and large values capped.
    always_comb
    begin
        rows_eff = CNT_W'(num_rows_reg);
        if (num_rows_reg == '0)
        begin
            rows_eff = CNT_W'(1);
        end
        else if (CNT_W'(num_rows_reg) > CNT_W'(MAX_ROWS))
        begin
            rows_eff = CNT_W'(MAX_ROWS);
        end
    end

    // New best sum for the current entry, saturating.
    always_comb
    begin
        last_col  = (col_reg == row_reg);
        last_row  = ((CNT_W'(row_reg) + CNT_W'(1)) >= rows_eff);
        old_here  = last_col ? '0 : head_best;
        left_cand = (col_reg == '0) ? '0 : left_reg;
        pick      = (left_cand > old_here) ? left_cand : old_here;
        sum_wide  = {1'b0, pick} + (SUM_W + 1)'(entry_value);
        best      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        bmax_upd  = ((col_reg == '0) || (best > bmax_reg)) ? best : bmax_reg;
    end

    // Chain control: pop the head for every column but the last of a row.
    always_comb
    begin
        ctl.push = accept;
        ctl.pop  = !last_col;
        ctl.tail = last_col ? row_reg : row_reg - IDX_W'(1);
        ctl.data = best;
    end

    // Result of a finished triangle.
    assign res_valid = accept && last_col && last_row;
    assign res_sum   = bmax_upd;

    // Next-state logic for counters and running values.
    always_comb
    begin
        num_rows_next = cfg_we ? cfg_wdata : num_rows_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        left_next     = left_reg;
        bmax_next     = bmax_reg;
        if (accept)
        begin
            left_next = old_here;
            if (last_row)
            begin
                bmax_next = bmax_upd;
            end
            if (last_col)
            begin
                col_next  = '0;
                left_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    bmax_next = '0;
                end
                else
                begin
                    row_next = row_reg + IDX_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_W'(100);
            row_reg      <= '0;
            col_reg      <= '0;
            left_reg     <= '0;
            bmax_reg     <= '0;
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            left_reg     <= left_next;
            bmax_reg     <= bmax_next;
        end
    end

endmodule
